// ===== design/swpr_pkg.sv =====
// Shared types and constants for the sliding window peak rate block.
`default_nettype none

package swpr_pkg;

  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 11;
  localparam int PERIOD_W = 31;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Word index of each register, taken from paddr[2]
  localparam logic REG_WINDOW_SECONDS = 1'b0;

  localparam logic [PERIOD_W-1:0] WINDOW_SECONDS_RST = PERIOD_W'(1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CHK  = 2'b10
  } swpr_state_t;

endpackage

`default_nettype wire

// ===== design/swpr_if.sv =====
// Request channel interfaces for event timestamps and window results.
`default_nettype none

interface swpr_in_if;
  import swpr_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] event_time;

  modport source (output valid, output event_time, input ready);
  modport sink   (input valid, input event_time, output ready);
endinterface

interface swpr_out_if;
  import swpr_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] window_count;
  logic [COUNT_W-1:0] peak_count;
  logic [TIME_W-1:0]  peak_start;
  logic [TIME_W-1:0]  peak_end;
  logic               overflow;

  modport source (output valid, output window_count, output peak_count,
                  output peak_start, output peak_end, output overflow, input ready);
  modport sink   (input valid, input window_count, input peak_count,
                  input peak_start, input peak_end, input overflow, output ready);
endinterface

`default_nettype wire

// ===== design/swpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module swpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/swpr_cfg.sv =====
// APB-style register file holding the window length.
`default_nettype none

module swpr_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [swpr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [swpr_pkg::CFG_DATA_W-1:0]  pwdata,
  output      logic [swpr_pkg::CFG_DATA_W-1:0]  prdata,
  output      logic                             pready,
  output      logic [swpr_pkg::PERIOD_W-1:0]    period
);
  import swpr_pkg::*;

  logic [PERIOD_W-1:0] window_seconds_r;
  logic [PERIOD_W-1:0] window_seconds_nxt;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[2] == REG_WINDOW_SECONDS);

  always_comb begin
    window_seconds_nxt = window_seconds_r;
    if (wr_en) begin
      window_seconds_nxt = pwdata[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_seconds_r <= WINDOW_SECONDS_RST;
    end else begin
      window_seconds_r <= window_seconds_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW_SECONDS) begin
      prdata = {{(CFG_DATA_W-PERIOD_W){1'b0}}, window_seconds_r};
    end
  end

  // A zero period behaves as one second
  assign period = (window_seconds_r == '0) ? PERIOD_W'(1) : window_seconds_r;

endmodule

`default_nettype wire

// ===== design/sliding_window_peak_rate.sv =====
// Top level: sliding time window event counter with peak tracking.
//
// in_if carries one event timestamp (seconds) per request; out_if returns one
// result per event: the count now in the window, the peak count since reset
// with the oldest and newest timestamps of that peak window, and an overflow
// flag when the ring was full and its oldest entry was forced out.
// The window length is set through the cfg_ APB-style port (register 0,
// window_seconds); write it only while no event is in flight.
// The result register loads as the window check (S_CHK) that follows an
// accepted event ends; the check runs on for every old entry dropped from the
// window: the timestamp ring sits in one RAM with a single read port and
// registered read data, and each comparison against the oldest entry waits on
// that read. in_if.ready is low during the check: no new event until it ends.
// The result register holds while out_if.ready is low; the next event is
// accepted meanwhile and waits at its final step until the register frees.
// Reset empties the window, clears the peak and sets window_seconds to 1.
// The ring RAM needs no clearing: data from an unoccupied entry is never used.
`default_nettype none

module sliding_window_peak_rate #(
  parameter int WINDOW_DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  swpr_in_if.sink                               in_if,
  swpr_out_if.source                            out_if,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [swpr_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [swpr_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output      logic [swpr_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output      logic                             cfg_pready
);
  import swpr_pkg::*;

  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int OCC_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WINDOW_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(WINDOW_DEPTH);

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

  logic [PERIOD_W-1:0] period;

  swpr_state_t         state_r, state_nxt;
  logic [PTR_W-1:0]    oldest_r, oldest_nxt;
  logic [PTR_W-1:0]    newest_r, newest_nxt;
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic [OCC_W-1:0]    best_count_r, best_count_nxt;
  logic [TIME_W-1:0]   best_start_r, best_start_nxt;
  logic [TIME_W-1:0]   best_end_r, best_end_nxt;
  logic [TIME_W-1:0]   t_r, t_nxt;
  logic                fwd_r, fwd_nxt;
  logic                ovf_r, ovf_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OCC_W-1:0]    out_count_r, out_count_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic                in_take;
  logic                full;
  logic [PTR_W-1:0]    acc_oldest;
  logic [TIME_W-1:0]   old_time;
  logic [TIME_W-1:0]   age;
  logic                pop;
  logic                out_free;
  logic                finish;

  logic                ram_we;
  logic                ram_re;
  logic [PTR_W-1:0]    ram_raddr;
  logic [TIME_W-1:0]   ram_rdata;

  swpr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .period  (period)
  );

  swpr_ram #(
    .WIDTH (TIME_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (newest_r),
    .wdata (in_if.event_time),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_if.ready = (state_r == S_IDLE);
  assign in_take     = in_if.valid & in_if.ready;
  assign full        = (occ_r == FULL_OCC);
  assign acc_oldest  = full ? next_slot(oldest_r) : oldest_r;

  // An empty ring means the oldest entry is the one just written
  assign old_time = fwd_r ? t_r : ram_rdata;
  assign age      = t_r - old_time;
  assign pop      = (state_r == S_CHK) && (occ_r > OCC_W'(1)) && (t_r >= old_time)
                    && (age >= {{(TIME_W-PERIOD_W){1'b0}}, period});
  assign out_free = ~out_valid_r | out_if.ready;
  assign finish   = (state_r == S_CHK) && !pop && out_free;

  assign ram_we    = in_take;
  assign ram_re    = in_take | pop;
  assign ram_raddr = in_take ? acc_oldest : next_slot(oldest_r);

  always_comb begin
    state_nxt      = state_r;
    oldest_nxt     = oldest_r;
    newest_nxt     = newest_r;
    occ_nxt        = occ_r;
    best_count_nxt = best_count_r;
    best_start_nxt = best_start_r;
    best_end_nxt   = best_end_r;
    t_nxt          = t_r;
    fwd_nxt        = fwd_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = out_valid_r & ~out_if.ready;
    out_count_nxt  = out_count_r;
    out_ovf_nxt    = out_ovf_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          // drop the oldest when full, then push
          t_nxt      = in_if.event_time;
          ovf_nxt    = full;
          fwd_nxt    = (occ_r == '0);
          oldest_nxt = acc_oldest;
          newest_nxt = next_slot(newest_r);
          occ_nxt    = full ? occ_r : occ_r + OCC_W'(1);
          state_nxt  = S_CHK;
        end
      end
      S_CHK: begin
        if (pop) begin
          oldest_nxt = next_slot(oldest_r);
          occ_nxt    = occ_r - OCC_W'(1);
          fwd_nxt    = 1'b0;
        end else if (finish) begin
          if (occ_r > best_count_r) begin
            best_count_nxt = occ_r;
            best_start_nxt = old_time;
            best_end_nxt   = t_r;
          end
          out_valid_nxt = 1'b1;
          out_count_nxt = occ_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      oldest_r     <= '0;
      newest_r     <= '0;
      occ_r        <= '0;
      best_count_r <= '0;
      best_start_r <= '0;
      best_end_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      oldest_r     <= oldest_nxt;
      newest_r     <= newest_nxt;
      occ_r        <= occ_nxt;
      best_count_r <= best_count_nxt;
      best_start_r <= best_start_nxt;
      best_end_r   <= best_end_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    fwd_r       <= fwd_nxt;
    ovf_r       <= ovf_nxt;
    out_count_r <= out_count_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.window_count = COUNT_W'(out_count_r);
  assign out_if.peak_count   = COUNT_W'(best_count_r);
  assign out_if.peak_start   = best_start_r;
  assign out_if.peak_end     = best_end_r;
  assign out_if.overflow     = out_ovf_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_OCC)
    else $error("occupancy beyond ring depth");

  a_chk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (occ_r != '0))
    else $error("window check with empty ring");

  a_take_to_chk: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == S_CHK))
    else $error("accepted request did not start a window check");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CHK) && !pop && out_valid_r && !out_if.ready)
    |=> (state_r == S_CHK))
    else $error("result finished while output register still full");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (best_count_r >= $past(best_count_r)))
    else $error("peak count decreased");
`endif

endmodule

`default_nettype wire

// ===== tb/sliding_window_peak_rate_tb.sv =====
// Testbench for the sliding window peak rate block: predicted window results against the DUT.
`timescale 1ns / 100ps

module sliding_window_peak_rate_tb;
  import swpr_pkg::*;

  localparam int DEPTH = 1024;
  localparam int HALF_PERIOD_NS = 6;
  localparam int TIMEOUT_NS = 5_000_000;
  localparam int MAX_PRINTED = 30;

  localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW_SECONDS = CFG_ADDR_W'(4 * REG_WINDOW_SECONDS);
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED       = CFG_ADDR_W'(4);

  localparam logic [CFG_DATA_W-1:0] PERIOD_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [COUNT_W-1:0] window_count;
    logic [COUNT_W-1:0] peak_count;
    logic [TIME_W-1:0]  peak_start;
    logic [TIME_W-1:0]  peak_end;
    logic               overflow;
  } window_result_t;

  class peak_rate_scoreboard;
    logic [TIME_W-1:0]   stamps[DEPTH];
    int                  head;
    int                  tail;
    int                  fill;
    int                  peak;
    logic [TIME_W-1:0]   peak_first;
    logic [TIME_W-1:0]   peak_last;
    logic [PERIOD_W-1:0] win_len;
    window_result_t      windows_due[$];
    int                  errors;

    function new();
      head = 0;
      tail = 0;
      fill = 0;
      peak = 0;
      peak_first = '0;
      peak_last = '0;
      win_len = WINDOW_SECONDS_RST;
      errors = 0;
    endfunction

    function int pending();
      return windows_due.size();
    endfunction

    function void write_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if ((addr >> 2) == REG_WINDOW_SECONDS)
        win_len = data[PERIOD_W-1:0];
    endfunction

    // Push one timestamp, age out the stale ones, update the peak.
    function window_result_t predict_window(logic [TIME_W-1:0] t);
      window_result_t      r;
      logic [TIME_W-1:0]   period;
      logic [TIME_W-1:0]   old;
      bit                  done;
      period = (win_len == '0) ? TIME_W'(1) : TIME_W'(win_len);
      r.overflow = 1'b0;
      if (fill >= DEPTH) begin
        head = (head + 1) % DEPTH;
        fill--;
        r.overflow = 1'b1;
      end
      stamps[tail] = t;
      tail = (tail + 1) % DEPTH;
      fill++;
      done = 0;
      while (fill > 1 && !done) begin
        old = stamps[head];
        if (t < old || (t - old) < period) begin
          done = 1;
        end else begin
          head = (head + 1) % DEPTH;
          fill--;
        end
      end
      // strictly greater only: a tie keeps the earlier window
      if (fill > peak) begin
        peak = fill;
        peak_first = stamps[head];
        peak_last = t;
      end
      r.window_count = COUNT_W'(fill);
      r.peak_count = COUNT_W'(peak);
      r.peak_start = peak_first;
      r.peak_end = peak_last;
      return r;
    endfunction

    function void note_event(logic [TIME_W-1:0] t);
      windows_due.push_back(predict_window(t));
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("%0t mismatch: %s", $time, what);
    endtask

    task check_result(window_result_t got);
      window_result_t want;
      if (windows_due.size() == 0) begin
        report_mismatch($sformatf("result with no request outstanding: %p", got));
      end else begin
        want = windows_due.pop_front();
        if (got.window_count !== want.window_count)
          report_mismatch($sformatf("window_count got %0d want %0d",
                                    got.window_count, want.window_count));
        if (got.peak_count !== want.peak_count)
          report_mismatch($sformatf("peak_count got %0d want %0d",
                                    got.peak_count, want.peak_count));
        if (got.peak_start !== want.peak_start)
          report_mismatch($sformatf("peak_start got %h want %h",
                                    got.peak_start, want.peak_start));
        if (got.peak_end !== want.peak_end)
          report_mismatch($sformatf("peak_end got %h want %h",
                                    got.peak_end, want.peak_end));
        if (got.overflow !== want.overflow)
          report_mismatch($sformatf("overflow got %b want %b",
                                    got.overflow, want.overflow));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  swpr_in_if  in_ch();
  swpr_out_if out_ch();

  sliding_window_peak_rate #(
    .WINDOW_DEPTH(DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  peak_rate_scoreboard sb = new();

  int                burst_left = 0;
  logic [TIME_W-1:0] last_time = '0;

  initial clk = 1'b0;
  always begin
    #HALF_PERIOD_NS clk = 1'b1;
    #HALF_PERIOD_NS clk = 1'b0;
  end

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_event(in_ch.event_time);
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.window_count, out_ch.peak_count, out_ch.peak_start,
                          out_ch.peak_end, out_ch.overflow});
    end
  end

  // Receiver: stretches of steady ready, random stalls and long holds.
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(8, 60);
      end
      left--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= (left < 3);
      endcase
    end
  end

  task send_event(logic [TIME_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        in_ch.event_time <= $urandom;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.event_time <= t;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop the request and hold until every result is back.
  task wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_register(addr, data);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Mostly forward steps; some backward jumps, and in noisy phases wild stamps.
  task run_phase(logic [CFG_DATA_W-1:0] period, int items, int unsigned step, bit noisy);
    int                r;
    logic [TIME_W-1:0] t;
    cfg_write(ADDR_WINDOW_SECONDS, period);
    repeat (items) begin
      r = $urandom_range(0, 31);
      if (noisy && r == 0)
        t = $urandom;
      else if (r < 3)
        t = last_time - $urandom_range(0, 4 * step + 1);
      else
        t = last_time + $urandom_range(0, step);
      last_time = t;
      send_event(t);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.event_time = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset period of one second: equal stamps, ageing out, time running backwards
    send_event(32'd0);
    send_event(32'd0);
    send_event(32'd1);
    send_event(32'hFFFF_FFFF);
    send_event(32'd5);
    send_event(32'd5);
    send_event(32'd6);

    // zero period behaves as one
    cfg_write(ADDR_WINDOW_SECONDS, '0);
    send_event(32'd10);
    send_event(32'd10);
    send_event(32'd11);
    send_event(32'd11);

    // write beyond the register list must leave the period alone
    cfg_write(ADDR_UNMAPPED, 32'd1000);
    send_event(32'd20);
    send_event(32'd20);
    send_event(32'd21);

    // top data bit is masked off: longest period
    cfg_write(ADDR_WINDOW_SECONDS, 32'hFFFF_FFFF);
    send_event(32'd0);
    send_event(32'h7FFF_FFFE);
    send_event(32'h7FFF_FFFF);
    send_event(32'hFFFF_FFFF);
    send_event(32'h8000_0000);

    last_time = $urandom;
    run_phase(32'd3, 8, 2, 1);
    run_phase(32'($urandom_range(1, 50)), 8, 40, 1);
    run_phase(32'd1, 8, 1, 1);
    run_phase($urandom & PERIOD_MAX, 8, 32'h4000_0000, 1);
    // fill the ring past its depth so the oldest stamps are forced out
    run_phase(PERIOD_MAX, 1030, 3, 0);
    // short period again: the first step empties most of the ring
    last_time = last_time + 32'd100;
    run_phase(32'd2, 8, 3, 1);

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sliding_window_peak_rate.f =====
design/swpr_pkg.sv
design/swpr_if.sv
design/swpr_ram.sv
design/swpr_cfg.sv
design/sliding_window_peak_rate.sv
tb/sliding_window_peak_rate_tb.sv
